FILE: sv/gha_pkg.sv
package gha_pkg;

    localparam int unsigned BLOCK_W        = 128;
    localparam int unsigned HALF_W         = 64;
    localparam int unsigned DIGIT_BITS_DEF = 8;
    localparam int unsigned DATA_W         = 64;
    localparam int unsigned ADDR_W         = 4;

    // reduction constant, 0xe1 followed by 120 zero bits
    localparam logic [BLOCK_W-1:0] R_POLY = {8'he1, 120'd0};

    // register select, taken from paddr[3]
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_HOLD
    } state_t;

endpackage

FILE: sv/ghash_accumulator_unit.sv
// channel   | valid         | stall         | payload
// ----------+---------------+---------------+----------------------------------
// block     | block_valid   | block_stall   | block_high, block_low, restart
// digest    | digest_valid  | digest_stall  | digest_high, digest_low
// config    | apb write     | pready = 1    | paddr, pwdata (key high 0, low 8)
//
// each transaction runs through the digit-serial gf(2^128) multiplier, which absorbs
// DIGIT_BITS operand bits a cycle (8-bit digit by default)
// a new block is taken in the cycle the multiplier hands its product to the output register
// while the output register is full at the end of a product, the block side stalls
// reset clears the hash key, the accumulator and all handshake state

module ghash_accumulator_unit #(
    parameter int unsigned DIGIT_BITS = gha_pkg::DIGIT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        block_valid,
    output logic                        block_stall,
    input  logic [gha_pkg::HALF_W-1:0]  block_high,
    input  logic [gha_pkg::HALF_W-1:0]  block_low,
    input  logic                        restart,

    output logic                        digest_valid,
    input  logic                        digest_stall,
    output logic [gha_pkg::HALF_W-1:0]  digest_high,
    output logic [gha_pkg::HALF_W-1:0]  digest_low,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gha_pkg::ADDR_W-1:0]  paddr,
    input  logic [gha_pkg::DATA_W-1:0]  pwdata,
    output logic [gha_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int unsigned NUM_DIGITS = (gha_pkg::BLOCK_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int unsigned CNT_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    gha_pkg::state_t                state_reg, state_next;

    logic [gha_pkg::HALF_W-1:0]     key_high_reg;
    logic [gha_pkg::HALF_W-1:0]     key_low_reg;

    logic [gha_pkg::BLOCK_W-1:0]    y_reg;
    logic [gha_pkg::BLOCK_W-1:0]    a_reg, a_next;
    logic [gha_pkg::BLOCK_W-1:0]    v_reg, v_next;
    logic [gha_pkg::BLOCK_W-1:0]    z_reg, z_next;
    logic [CNT_W-1:0]               cnt_reg;

    logic                           digest_valid_reg;
    logic [gha_pkg::BLOCK_W-1:0]    digest_reg;

    logic                           last_digit;
    logic                           out_free;
    logic                           block_acc;
    logic                           step;
    logic                           load_from_mul;
    logic                           load_from_y;
    logic [gha_pkg::BLOCK_W-1:0]    y_src;
    logic                           cfg_wr;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[3] == gha_pkg::REG_KEY_LOW) ? key_low_reg : key_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3])
                gha_pkg::REG_KEY_HIGH: key_high_reg <= pwdata;
                gha_pkg::REG_KEY_LOW:  key_low_reg  <= pwdata;
                default:               key_high_reg <= key_high_reg;
            endcase
        end
    end

    // one digit of the multiplier
    always_comb
    begin
        z_next = z_reg;
        v_next = v_reg;
        for (int unsigned d = 0; d < DIGIT_BITS; d++)
        begin
            if (a_reg[gha_pkg::BLOCK_W-1-d])
                z_next = z_next ^ v_next;
            v_next = {1'b0, v_next[gha_pkg::BLOCK_W-1:1]}
                     ^ (v_next[0] ? gha_pkg::R_POLY : '0);
        end
        a_next = a_reg << DIGIT_BITS;
    end

    assign last_digit = (cnt_reg == CNT_W'(NUM_DIGITS - 1));
    assign out_free   = ~digest_valid_reg | ~digest_stall;
    assign block_acc  = block_valid & ~block_stall;
    assign y_src      = (state_reg == gha_pkg::ST_IDLE) ? y_reg : z_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gha_pkg::ST_IDLE:
            begin
                if (block_valid)
                    state_next = gha_pkg::ST_MUL;
            end
            gha_pkg::ST_MUL:
            begin
                if (last_digit)
                begin
                    if (!out_free)
                        state_next = gha_pkg::ST_HOLD;
                    else if (block_valid)
                        state_next = gha_pkg::ST_MUL;
                    else
                        state_next = gha_pkg::ST_IDLE;
                end
            end
            gha_pkg::ST_HOLD:
            begin
                if (out_free)
                    state_next = gha_pkg::ST_IDLE;
            end
            default: state_next = gha_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        block_stall   = 1'b1;
        step          = 1'b0;
        load_from_mul = 1'b0;
        load_from_y   = 1'b0;
        unique case (state_reg)
            gha_pkg::ST_IDLE:
            begin
                block_stall = 1'b0;
            end
            gha_pkg::ST_MUL:
            begin
                step          = 1'b1;
                load_from_mul = last_digit & out_free;
                block_stall   = ~(last_digit & out_free);
            end
            gha_pkg::ST_HOLD:
            begin
                load_from_y = out_free;
            end
            default: block_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gha_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (step && last_digit)
                y_reg <= z_next;
            if (block_acc)
                cnt_reg <= '0;
            else if (step)
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // multiplier datapath
    always_ff @(posedge clk)
    begin
        if (block_acc)
        begin
            a_reg <= (restart ? '0 : y_src) ^ {block_high, block_low};
            v_reg <= {key_high_reg, key_low_reg};
            z_reg <= '0;
        end
        else if (step)
        begin
            a_reg <= a_next;
            v_reg <= v_next;
            z_reg <= z_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digest_valid_reg <= 1'b0;
        else if (load_from_mul || load_from_y)
            digest_valid_reg <= 1'b1;
        else if (!digest_stall)
            digest_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_from_mul)
            digest_reg <= z_next;
        else if (load_from_y)
            digest_reg <= y_reg;
    end

    assign digest_valid = digest_valid_reg;
    assign digest_high  = digest_reg[gha_pkg::BLOCK_W-1:gha_pkg::HALF_W];
    assign digest_low   = digest_reg[gha_pkg::HALF_W-1:0];

    a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
        block_acc |=> state_reg == gha_pkg::ST_MUL)
        else $error("block taken without starting the multiplier");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gha_pkg::ST_HOLD |-> digest_valid_reg)
        else $error("holding a product while the output register is empty");

    a_enter_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gha_pkg::ST_MUL && last_digit && digest_valid_reg && digest_stall)
        |=> state_reg == gha_pkg::ST_HOLD)
        else $error("finished product lost while output stalled");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (load_from_mul || load_from_y) |-> out_free)
        else $error("output register overwritten");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned CLK_HALF   = 4;
    localparam int unsigned CYCLE_CAP  = 500000;
    localparam int unsigned HOLD_LEN   = 400;
    localparam int unsigned SETTLE_CYC = 24;
    localparam int unsigned RAND_PHASES = 6;
    localparam int unsigned RAND_ITEMS  = 100;

    localparam logic [gha_pkg::ADDR_W-1:0] KEY_HIGH_ADDR = {gha_pkg::REG_KEY_HIGH, 3'b000};
    localparam logic [gha_pkg::ADDR_W-1:0] KEY_LOW_ADDR  = {gha_pkg::REG_KEY_LOW, 3'b000};

    localparam logic [gha_pkg::HALF_W-1:0] ONES  = {gha_pkg::HALF_W{1'b1}};
    localparam logic [gha_pkg::HALF_W-1:0] ZERO  = '0;
    localparam logic [gha_pkg::HALF_W-1:0] TOP1  = {1'b1, {(gha_pkg::HALF_W-1){1'b0}}};
    localparam logic [gha_pkg::HALF_W-1:0] LOW1  = {{(gha_pkg::HALF_W-1){1'b0}}, 1'b1};
    localparam logic [gha_pkg::HALF_W-1:0] PAT_A = 64'h0123456789abcdef;
    localparam logic [gha_pkg::HALF_W-1:0] PAT_B = 64'hfedcba9876543210;

    typedef struct packed {
        logic                       key_wr;
        logic [gha_pkg::HALF_W-1:0] key_high;
        logic [gha_pkg::HALF_W-1:0] key_low;
        logic [gha_pkg::HALF_W-1:0] blk_high;
        logic [gha_pkg::HALF_W-1:0] blk_low;
        logic                       rst_acc;
        logic                       typed;
        logic [gha_pkg::HALF_W-1:0] want_high;
        logic [gha_pkg::HALF_W-1:0] want_low;
    } dir_row_t;

    typedef struct packed {
        logic [gha_pkg::HALF_W-1:0] high;
        logic [gha_pkg::HALF_W-1:0] low;
    } digest_t;

    localparam int unsigned DIR_ROWS = 20;

    // zero key after reset, then identity key, then assorted keys checked by prediction
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{1'b0, ZERO, ZERO, ONES, ONES, 1'b1, 1'b1, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, ZERO, ZERO, 1'b0, 1'b1, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, TOP1, LOW1, 1'b0, 1'b1, ZERO, ZERO},
        '{1'b1, TOP1, ZERO, PAT_A, PAT_B, 1'b0, 1'b1, PAT_A, PAT_B},
        '{1'b0, ZERO, ZERO, PAT_A, PAT_B, 1'b0, 1'b1, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, ONES, ONES, 1'b0, 1'b1, ONES, ONES},
        '{1'b0, ZERO, ZERO, ZERO, ZERO, 1'b1, 1'b1, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, TOP1, ZERO, 1'b1, 1'b1, TOP1, ZERO},
        '{1'b0, ZERO, ZERO, ZERO, LOW1, 1'b0, 1'b1, TOP1, LOW1},
        '{1'b1, ONES, ONES, ONES, ONES, 1'b0, 1'b0, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, ZERO, ZERO, 1'b1, 1'b0, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, TOP1, ZERO, 1'b0, 1'b0, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, ZERO, LOW1, 1'b0, 1'b0, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, PAT_B, PAT_A, 1'b1, 1'b0, ZERO, ZERO},
        '{1'b1, ZERO, LOW1, TOP1, ZERO, 1'b0, 1'b0, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, ONES, ONES, 1'b0, 1'b0, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, ZERO, ZERO, 1'b0, 1'b0, ZERO, ZERO},
        '{1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e,
          64'h0388dace60b6a392, 64'hf328c2b971b2fe78, 1'b1, 1'b0, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, ZERO, ZERO, 1'b0, 1'b0, ZERO, ZERO},
        '{1'b0, ZERO, ZERO, ZERO, ZERO, 1'b1, 1'b0, ZERO, ZERO}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;

    logic                       block_valid = 1'b0;
    logic                       block_stall;
    logic [gha_pkg::HALF_W-1:0] block_high = '0;
    logic [gha_pkg::HALF_W-1:0] block_low = '0;
    logic                       restart = 1'b0;

    logic                       digest_valid;
    logic                       digest_stall = 1'b0;
    logic [gha_pkg::HALF_W-1:0] digest_high;
    logic [gha_pkg::HALF_W-1:0] digest_low;

    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [gha_pkg::ADDR_W-1:0] paddr = '0;
    logic [gha_pkg::DATA_W-1:0] pwdata = '0;
    logic [gha_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    // typed expectation travelling with the block transaction
    logic                       typed_on = 1'b0;
    logic [gha_pkg::HALF_W-1:0] typed_high = '0;
    logic [gha_pkg::HALF_W-1:0] typed_low = '0;

    digest_t           digest_q [$];
    int unsigned       err_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       hold_requests = 0;

    ghash_accumulator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .block_valid  (block_valid),
        .block_stall  (block_stall),
        .block_high   (block_high),
        .block_low    (block_low),
        .restart      (restart),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_high  (digest_high),
        .digest_low   (digest_low),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // product in gf(2^128), gcm bit order, bit 127 of the vectors is bit 0 of the field
    function automatic logic [gha_pkg::BLOCK_W-1:0] gf_mul_by_key(
        input logic [gha_pkg::BLOCK_W-1:0] y,
        input logic [gha_pkg::BLOCK_W-1:0] h);
        logic [gha_pkg::BLOCK_W-1:0] z;
        logic [gha_pkg::BLOCK_W-1:0] v;
        logic                        lsb;
        z = '0;
        v = h;
        for (int i = 0; i < gha_pkg::BLOCK_W; i++)
        begin
            if (y[gha_pkg::BLOCK_W-1-i])
                z = z ^ v;
            lsb = v[0];
            v = v >> 1;
            if (lsb)
                v = v ^ gha_pkg::R_POLY;
        end
        return z;
    endfunction

    function automatic logic [gha_pkg::HALF_W-1:0] rand_half();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return ZERO;
            1: return ONES;
            2: return LOW1 << $urandom_range(0, gha_pkg::HALF_W-1);
            3: return ~(LOW1 << $urandom_range(0, gha_pkg::HALF_W-1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver: stall pattern of its own plus long hold-offs on request
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int unsigned stall_mode = 0;

    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_LEN;
            digest_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            digest_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(64, 256);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: digest_stall <= 1'b0;
                1: digest_stall <= ($urandom_range(0, 3) == 0);
                2: digest_stall <= ($urandom_range(0, 1) == 0);
                default: digest_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // key and accumulator tracking, digest comparison
    logic [gha_pkg::HALF_W-1:0]  key_high_m = '0;
    logic [gha_pkg::HALF_W-1:0]  key_low_m = '0;
    logic [gha_pkg::BLOCK_W-1:0] acc_m = '0;

    always @(posedge clk)
    begin : track
        digest_t                     want;
        logic [gha_pkg::BLOCK_W-1:0] y;
        if (rst_n)
        begin
            if (digest_valid && !digest_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("digest transaction with no block pending: %h %h",
                           digest_high, digest_low);
                    err_count++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (digest_high !== want.high)
                    begin
                        $error("digest_high: expected %h, got %h", want.high, digest_high);
                        err_count++;
                    end
                    if (digest_low !== want.low)
                    begin
                        $error("digest_low: expected %h, got %h", want.low, digest_low);
                        err_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    KEY_HIGH_ADDR: key_high_m = pwdata;
                    KEY_LOW_ADDR:  key_low_m  = pwdata;
                    default: ;
                endcase
            end
            if (block_valid && !block_stall)
            begin
                y = restart ? '0 : acc_m;
                y = y ^ {block_high, block_low};
                acc_m = gf_mul_by_key(y, {key_high_m, key_low_m});
                if (typed_on)
                    want = '{high: typed_high, low: typed_low};
                else
                    want = '{high: acc_m[gha_pkg::BLOCK_W-1:gha_pkg::HALF_W],
                             low: acc_m[gha_pkg::HALF_W-1:0]};
                digest_q.push_back(want);
            end
        end
    end

    task automatic send_block(input logic [gha_pkg::HALF_W-1:0] bh,
                              input logic [gha_pkg::HALF_W-1:0] bl,
                              input logic rs, input logic tp,
                              input logic [gha_pkg::HALF_W-1:0] th,
                              input logic [gha_pkg::HALF_W-1:0] tl);
        block_valid <= 1'b1;
        block_high  <= bh;
        block_low   <= bl;
        restart     <= rs;
        typed_on    <= tp;
        typed_high  <= th;
        typed_low   <= tl;
        do
            @(posedge clk);
        while (!(block_valid && !block_stall));
    endtask

    task automatic key_write(input logic [gha_pkg::ADDR_W-1:0] addr,
                             input logic [gha_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_digests();
        block_valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic load_key(input logic [gha_pkg::HALF_W-1:0] kh,
                            input logic [gha_pkg::HALF_W-1:0] kl);
        drain_digests();
        key_write(KEY_HIGH_ADDR, kh);
        key_write(KEY_LOW_ADDR, kl);
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned burst_left;
        int unsigned gap;
        logic [gha_pkg::HALF_W-1:0] kh;
        logic [gha_pkg::HALF_W-1:0] kl;
        logic                       pressure;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIR_TAB[r].key_wr)
                load_key(DIR_TAB[r].key_high, DIR_TAB[r].key_low);
            send_block(DIR_TAB[r].blk_high, DIR_TAB[r].blk_low, DIR_TAB[r].rst_acc,
                       DIR_TAB[r].typed, DIR_TAB[r].want_high, DIR_TAB[r].want_low);
            if ($urandom_range(0, 2) == 0)
            begin
                block_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: begin kh = {$urandom, $urandom}; kl = {$urandom, $urandom}; end
                1: begin kh = ONES; kl = ONES; end
                2: begin kh = ZERO; kl = ZERO; end
                3: begin kh = TOP1; kl = ZERO; end
                4: begin kh = ZERO; kl = LOW1; end
                default: begin kh = {$urandom, $urandom}; kl = {$urandom, $urandom}; end
            endcase
            load_key(kh, kl);
            burst_left = $urandom_range(1, 16);
            pressure = 1'b0;
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                // long receiver hold-off while blocks keep coming back to back
                if (p == 0 && n == 30)
                begin
                    hold_requests <= hold_requests + 1;
                    pressure = 1'b1;
                end
                if (p == 0 && n == 70)
                    pressure = 1'b0;
                // sender pause until every digest is back
                if (p == 5 && n == 50)
                    drain_digests();
                send_block(rand_half(), rand_half(), ($urandom_range(0, 7) == 0),
                           1'b0, ZERO, ZERO);
                if (!pressure)
                begin
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            burst_left = $urandom_range(20, 40);
                        else
                        begin
                            gap = $urandom_range(1, 12);
                            block_valid <= 1'b0;
                            repeat (gap) @(posedge clk);
                            burst_left = $urandom_range(1, 16);
                        end
                    end
                end
            end
        end

        drain_digests();
        repeat (40) @(posedge clk);
        if (digest_q.size() != 0)
        begin
            $error("%0d digest transactions never arrived", digest_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
